/* sv/tirt_pkg.sv */
// ----------------------------------------------------------------------------
// tirt_pkg
// Shared types and codes for the transaction ID remap table.
// ----------------------------------------------------------------------------
package tirt_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_FREE    = 2'd2;
  localparam logic [1:0] CMD_LOOKUP  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] client_xid;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [15:0] upstream_xid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_txid;
    logic [15:0] found_client_xid;
    logic [31:0] found_client_ip;
    logic [15:0] found_client_port;
  } out_word_t;

  // Classified request as held between front and back
  typedef struct packed {
    logic        is_alloc;
    logic        want_fields;
    logic        do_free;
    logic [15:0] client_xid;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [15:0] upstream_xid;
  } job_t;

endpackage

/* sv/tirt_front.sv */
// ----------------------------------------------------------------------------
// tirt_front
// Request intake: decodes the command and queues the job for the engine.
// ----------------------------------------------------------------------------
module tirt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tirt_pkg::in_word_t req,
  output logic            job_valid,
  input  logic            job_take,
  output tirt_pkg::job_t  job
);
  import tirt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t              slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  job_t              job_in;
  logic              wr_en;
  logic              rd_en;

  always_comb begin
    job_in.is_alloc     = (req.cmd == CMD_ALLOC);
    job_in.want_fields  = (req.cmd == CMD_RESOLVE) || (req.cmd == CMD_LOOKUP);
    job_in.do_free      = (req.cmd == CMD_RESOLVE) || (req.cmd == CMD_FREE);
    job_in.client_xid   = req.client_xid;
    job_in.client_ip    = req.client_ip;
    job_in.client_port  = req.client_port;
    job_in.upstream_xid = req.upstream_xid;
  end

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign job_valid = (count != '0);
  assign job       = slot[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule

/* sv/tirt_back.sv */
// ----------------------------------------------------------------------------
// tirt_back
// Table engine: parallel compare, lowest-index pick, then update or read.
// ----------------------------------------------------------------------------
module tirt_back #(
  parameter int ENTRIES = tirt_pkg::ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  tirt_pkg::job_t     job,
  input  logic               res_space,
  output logic               res_push,
  output tirt_pkg::out_word_t res_word
);
  import tirt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_PICK  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [15:0] xid;
    logic [31:0] ip;
    logic [15:0] port;
  } client_rec_t;

  state_t               state;
  state_t               state_next;
  job_t                 cur;
  logic [ENTRIES-1:0]   busy;
  logic [15:0]          up_id [ENTRIES];
  logic [15:0]          next_id;
  logic [15:0]          id_inc;
  logic [ENTRIES-1:0]   match_vec;
  logic                 hit;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     enc_idx;
  client_rec_t          client_mem [ENTRIES];
  client_rec_t          rd_data;
  logic                 mem_we;
  logic                 go_read;

  assign job_take = (state == S_IDLE) && job_valid && res_space;
  assign id_inc   = next_id + 16'd1;
  assign mem_we   = (state == S_EXEC) && cur.is_alloc && hit;
  assign go_read  = !cur.is_alloc && hit && cur.want_fields;

  // lowest set bit wins
  always_comb begin
    enc_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        enc_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    state_next = state;
    res_push   = 1'b0;
    res_word   = '0;
    unique case (state)
      S_IDLE: begin
        if (job_take) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: state_next = S_PICK;
      S_PICK:  state_next = S_EXEC;
      S_EXEC: begin
        if (go_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
          res_push   = 1'b1;
          if (cur.is_alloc) begin
            res_word.status        = hit ? ST_OK : ST_FULL;
            res_word.assigned_txid = hit ? next_id : 16'd0;
          end else begin
            res_word.status = hit ? ST_OK : ST_NOMATCH;
          end
        end
      end
      S_READ: begin
        state_next                 = S_IDLE;
        res_push                   = 1'b1;
        res_word.status            = ST_OK;
        res_word.found_client_xid  = rd_data.xid;
        res_word.found_client_ip   = rd_data.ip;
        res_word.found_client_port = rd_data.port;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Job, compare vector and pick index
  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (state == S_MATCH) begin
      for (int k = 0; k < ENTRIES; k++) begin
        match_vec[k] <= cur.is_alloc ? !busy[k]
                                     : (busy[k] && (up_id[k] == cur.upstream_xid));
      end
    end
    if (state == S_PICK) begin
      hit <= |match_vec;
      idx <= enc_idx;
    end
    if (mem_we) begin
      up_id[idx] <= next_id;
    end
  end

  // Client field store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      client_mem[idx] <= '{xid: cur.client_xid, ip: cur.client_ip, port: cur.client_port};
    end
    rd_data <= client_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= '0;
      next_id <= 16'd1;
    end else begin
      state <= state_next;
      if (mem_we) begin
        busy[idx] <= 1'b1;
        next_id   <= (id_inc == 16'd0) ? 16'd1 : id_inc;
      end
      if ((state == S_EXEC) && !cur.is_alloc && hit && cur.do_free) begin
        busy[idx] <= 1'b0;
      end
    end
  end

endmodule

/* sv/tirt_resq.sv */
// ----------------------------------------------------------------------------
// tirt_resq
// Result queue between the table engine and the response port.
// ----------------------------------------------------------------------------
module tirt_resq (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  tirt_pkg::out_word_t wr_word,
  output logic                space,
  output logic                empty,
  input  logic                pop,
  output tirt_pkg::out_word_t rsp
);
  import tirt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_word_t         slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              wr_en;
  logic              rd_en;

  assign space = (count != CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rsp   = slot[rd_ptr];
  assign wr_en = wr && space;
  assign rd_en = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule

/* sv/transaction_id_remap_table_core.sv */
// ----------------------------------------------------------------------------
// transaction_id_remap_table_core
// Pending-request table: hands out upstream IDs on allocate and maps them
// back to the client's ID, address and port on resolve/free/lookup.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake          Word        Notes
//   -------  -----------------  ----------  ---------------------------------
//   request  push / full        req         in_word_t, one command per word
//   response empty / pop        rsp         out_word_t, one word per request
//
// Sequence: the engine takes a job, compares, picks and updates on an
//   allocate, a free or a miss, and adds a registered client-field read on
//   a resolve/lookup hit. It takes no new word from the request queue until
//   the current one is finished.
// Reset: synchronous; all entries go free, the ID counter goes to 1, both
//   queues empty. Entry contents are not cleared, so no clearing pass.
// Stalls: two-word queues on each side; the engine only starts a word when
//   the response queue has room, so a stalled consumer never loses results.
//
module transaction_id_remap_table_core #(
  parameter int ENTRIES = tirt_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tirt_pkg::in_word_t  req,
  output logic                empty,
  input  logic                pop,
  output tirt_pkg::out_word_t rsp
);
  import tirt_pkg::*;

  job_t      job;
  logic      job_valid;
  logic      job_take;
  logic      res_space;
  logic      res_push;
  out_word_t res_word;

  // Front: decode and buffer requests
  tirt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  // Back: table lookup and update
  tirt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .res_space (res_space),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  // Response buffering
  tirt_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_word (res_word),
    .space   (res_space),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for transaction_id_remap_table_core. A clocked driver
// feeds request words from a pending queue. A clocked monitor pops response
// words and compares them with a cycle-free model of the pending-request
// table. Phases vary the idle/stall mix and end with a drain of the table.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tirt_pkg::*;

  localparam int ENTRIES     = tirt_pkg::ENTRIES_DEFAULT;
  localparam int HOLD_CYCLES = 300;    // long consumer hold-off, fills both queues
  localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 20;     // > engine + queue latency
  localparam int PHASE_WORDS = 325;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  req = '0;
  logic      full;
  logic      empty;
  out_word_t rsp;

  transaction_id_remap_table_core #(.ENTRIES(ENTRIES)) DUT (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table model. Updated once per accepted request word, in accept order.
  // Entry contents start unknown; they are only read while busy, so the
  // RTL's uncleared contents never matter.
  // --------------------------------------------------------------------------
  bit          tbl_busy      [ENTRIES];
  logic [15:0] tbl_client_id [ENTRIES];
  logic [15:0] tbl_up_id     [ENTRIES];
  logic [31:0] tbl_ip        [ENTRIES];
  logic [15:0] tbl_port      [ENTRIES];
  logic [15:0] tbl_next_id = 16'd1;

  // Upstream ID counter skips 0 on wrap.
  function automatic logic [15:0] next_txid(logic [15:0] v);
    return (v == 16'hFFFF) ? 16'd1 : v + 16'd1;
  endfunction

  function automatic out_word_t remap_predict(in_word_t w);
    out_word_t r;
    int        slot;
    r    = '0;
    slot = -1;
    if (w.cmd == CMD_ALLOC) begin
      // lowest free entry: scan downward so the last hit is the lowest
      for (int k = ENTRIES - 1; k >= 0; k--)
        if (!tbl_busy[k]) slot = k;
      if (slot < 0) begin
        r.status = ST_FULL;          // counter holds
      end else begin
        tbl_busy[slot]      = 1'b1;
        tbl_client_id[slot] = w.client_xid;
        tbl_ip[slot]        = w.client_ip;
        tbl_port[slot]      = w.client_port;
        tbl_up_id[slot]     = tbl_next_id;
        r.status            = ST_OK;
        r.assigned_txid     = tbl_next_id;
        tbl_next_id         = next_txid(tbl_next_id);
      end
    end else begin
      // duplicates after a wrap: lowest-numbered busy entry wins
      for (int k = ENTRIES - 1; k >= 0; k--)
        if (tbl_busy[k] && tbl_up_id[k] == w.upstream_xid) slot = k;
      if (slot < 0) begin
        r.status = ST_NOMATCH;
      end else begin
        r.status = ST_OK;
        if (w.cmd != CMD_FREE) begin
          r.found_client_xid  = tbl_client_id[slot];
          r.found_client_ip   = tbl_ip[slot];
          r.found_client_port = tbl_port[slot];
        end
        if (w.cmd != CMD_LOOKUP) tbl_busy[slot] = 1'b0;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  in_word_t    pending_words [$];    // filled by the stimulus block
  out_word_t   results_due   [$];    // predicted responses, oldest first
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_arm       = 1'b0;
  int          hold_count     = 0;
  int          quiet_cycles   = 0;

  // Stimulus-side view of the table: which IDs are live and what the next
  // allocate will get. Only used to aim requests at live entries.
  logic [15:0] live_ids [$];
  logic [15:0] gen_next = 16'd1;

  // --------------------------------------------------------------------------
  // Driver: offer a word, hold it while full, predict on accept.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        results_due.push_back(remap_predict(req));
      end
      if (!push || !full) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req  <= pending_words.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each popped word with the oldest prediction.
  // The hold-off counter lives here so the stall length is exact.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected response st=%0d id=%h cid=%h ip=%h port=%h",
                     rsp.status, rsp.assigned_txid, rsp.found_client_xid,
                     rsp.found_client_ip, rsp.found_client_port);
        end else begin
          exp_w = results_due.pop_front();
          if (rsp.status            !== exp_w.status ||
              rsp.assigned_txid     !== exp_w.assigned_txid ||
              rsp.found_client_xid  !== exp_w.found_client_xid ||
              rsp.found_client_ip   !== exp_w.found_client_ip ||
              rsp.found_client_port !== exp_w.found_client_port) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: expected st=%0d id=%h cid=%h ip=%h port=%h",
                       exp_w.status, exp_w.assigned_txid, exp_w.found_client_xid,
                       exp_w.found_client_ip, exp_w.found_client_port);
              $display("       got      st=%0d id=%h cid=%h ip=%h port=%h",
                       rsp.status, rsp.assigned_txid, rsp.found_client_xid,
                       rsp.found_client_ip, rsp.found_client_port);
            end
          end
        end
      end
      if (hold_arm && hold_count < HOLD_CYCLES) begin
        hold_count <= hold_count + 1;
        pop        <= 1'b0;
      end else begin
        if (!hold_arm) hold_count <= 0;
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake resets the count.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Append a word and keep the live-ID view in step with it.
  task automatic queue_word(in_word_t w);
    if (w.cmd == CMD_ALLOC) begin
      if (live_ids.size() < ENTRIES) begin
        live_ids.push_back(gen_next);
        gen_next = next_txid(gen_next);
      end
    end else if (w.cmd != CMD_LOOKUP) begin
      for (int k = 0; k < live_ids.size(); k++)
        if (live_ids[k] == w.upstream_xid) begin
          live_ids.delete(k);
          break;
        end
    end
    pending_words.push_back(w);
  endtask

  // Unused fields carry random junk; the block must ignore them.
  function automatic in_word_t alloc_word(logic [15:0] cid, logic [31:0] ip,
                                          logic [15:0] port);
    in_word_t w;
    w.cmd          = CMD_ALLOC;
    w.client_xid   = cid;
    w.client_ip    = ip;
    w.client_port  = port;
    w.upstream_xid = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t id_word(logic [1:0] cmd, logic [15:0] id);
    in_word_t w;
    w.cmd          = cmd;
    w.client_xid   = 16'($urandom);
    w.client_ip    = $urandom;
    w.client_port  = 16'($urandom);
    w.upstream_xid = id;
    return w;
  endfunction

  // Allocates and requests aimed mostly at live IDs, with misses, ID 0 and the next ID mixed in.
  function automatic in_word_t random_word(int alloc_pct);
    in_word_t w;
    w = alloc_word(16'($urandom), $urandom, 16'($urandom));
    if ($urandom_range(99) >= alloc_pct) begin
      w.cmd = 2'($urandom_range(CMD_RESOLVE, CMD_LOOKUP));
      if (live_ids.size() > 0 && $urandom_range(99) < 80)
        w.upstream_xid = live_ids[$urandom_range(live_ids.size() - 1)];
      else if ($urandom_range(3) == 0)
        w.upstream_xid = $urandom_range(1) ? gen_next : 16'h0000;
    end
    return w;
  endfunction

  // Sender pause: wait until every word is accepted and answered.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_words.size() > 0 || push || results_due.size() > 0);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int          alloc_pct;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty table, extreme field values, fill to
    // full, free/resolve/lookup hits, reuse of the lowest free entry.
    queue_word(id_word(CMD_LOOKUP, 16'h0000));
    queue_word(id_word(CMD_RESOLVE, 16'hFFFF));
    queue_word(alloc_word(16'h0000, 32'h0000_0000, 16'h0000));      // ID 1
    queue_word(alloc_word(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));      // ID 2
    for (int k = 2; k < ENTRIES; k++)
      queue_word(alloc_word(16'($urandom), $urandom, 16'($urandom)));
    queue_word(alloc_word(16'h1234, 32'hC0A8_0001, 16'd53));        // table full
    queue_word(id_word(CMD_LOOKUP, 16'd2));
    queue_word(id_word(CMD_FREE, 16'd1));
    queue_word(id_word(CMD_RESOLVE, 16'd1));                        // already gone
    queue_word(id_word(CMD_RESOLVE, 16'd2));
    queue_word(alloc_word(16'hA5A5, 32'h5A5A_A5A5, 16'h8001));      // lands in entry 0
    queue_word(id_word(CMD_LOOKUP, 16'(ENTRIES + 1)));
    wait_quiet();

    // Random phases: none idle, sender idle, receiver stall, both.
    // First phase opens with a long consumer hold-off to back up the block.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 36 : 0;
      hold_arm       = (ph == 0);
      alloc_pct      = 50;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // swing between filling and draining so full and empty both occur
        if (n % 40 == 0) alloc_pct = $urandom_range(20, 75);
        queue_word(random_word(alloc_pct));
      end
      wait_quiet();
      hold_arm = 1'b0;
    end

    // Drain: free every live entry, then IDs 0 and not-yet-given must miss.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (live_ids.size() > 0)
      queue_word(id_word(CMD_FREE, live_ids[0]));
    queue_word(id_word(CMD_RESOLVE, 16'h0000));                     // 0 never given
    queue_word(id_word(CMD_LOOKUP, gen_next));
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tirt_pkg.sv
sv/tirt_front.sv
sv/tirt_back.sv
sv/tirt_resq.sv
sv/transaction_id_remap_table_core.sv
tb/tb_top.sv
